>>> src/mob_pkg.sv
// shared types and codes for the managed object bring-up state machine
// no dependencies; used by mob_step and managed_object_bringup_fsm
`timescale 1ns / 1ps
`default_nettype none

package mob_pkg;

    // object phase
    typedef enum logic [1:0] {
        PH_NOT_INSTALLED = 2'd0,
        PH_DEPENDENCY    = 2'd1,
        PH_OFFLINE       = 2'd2,
        PH_ENABLED       = 2'd3
    } t_phase;

    // command sent toward the peer
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_SET_ATTR  = 3'd1,
        CMD_UNLOCK    = 3'd2,
        CMD_LOCK      = 3'd3,
        CMD_OPSTART   = 3'd4
    } t_cmd;

    // event codes
    typedef enum logic [2:0] {
        OP_SW_ACT_REP   = 3'd0,
        OP_STATE_REPORT = 3'd1,
        OP_ATTR_ACK     = 3'd2,
        OP_OPSTART_ACK  = 3'd3,
        OP_OPSTART_NACK = 3'd4,
        OP_FORCE_LOCK   = 3'd5,
        OP_LINK_DOWN    = 3'd6
    } t_op;

    // reported availability codes
    localparam logic [2:0] AV_NOT_INSTALLED = 3'd0;
    localparam logic [2:0] AV_POWER_OFF     = 3'd1;
    localparam logic [2:0] AV_DEPENDENCY    = 3'd2;
    localparam logic [2:0] AV_OFF_LINE      = 3'd3;
    localparam logic [2:0] AV_OK            = 3'd4;

    // progress flags of the configure sequence
    typedef struct packed {
        logic attr_sent;
        logic attr_acked;
        logic unlock_sent;
        logic start_sent;
        logic forced_lock;
    } t_flags;

    // one incoming event
    typedef struct packed {
        logic [2:0] op;
        logic       new_enabled;
        logic [2:0] new_availability;
        logic       new_unlocked;
        logic       recorded_unlocked;
        logic       lock_request;
    } t_event;

    // outcome of one event
    typedef struct packed {
        t_phase phase;
        t_flags flags;
        t_cmd   cmd;
        logic   rejected;
    } t_step_res;

endpackage

`default_nettype wire

>>> src/mob_step.sv
// next-state and command logic for one event of the bring-up state machine
// depends on mob_pkg
`timescale 1ns / 1ps
`default_nettype none

module mob_step (
    input  wire mob_pkg::t_event    i_event,
    input  wire mob_pkg::t_phase    i_phase,
    input  wire mob_pkg::t_flags    i_flags,
    input  wire logic               i_skip_offline,
    output mob_pkg::t_step_res      o_res
);

    // one configure pass, at most one command
    function automatic mob_pkg::t_step_res configure(
        mob_pkg::t_step_res base, logic unlocked, logic allow_start);
        mob_pkg::t_step_res r;
        r = base;
        if (!r.flags.attr_sent && !r.flags.attr_acked) begin
            r.flags.attr_sent = 1'b1;
            r.cmd = mob_pkg::CMD_SET_ATTR;
        end else if (!unlocked && r.flags.attr_acked && !r.flags.unlock_sent) begin
            r.flags.unlock_sent = 1'b1;
            r.cmd = mob_pkg::CMD_UNLOCK;
        end else if (allow_start && unlocked && r.flags.attr_acked
                     && !r.flags.start_sent) begin
            r.flags.start_sent = 1'b1;
            r.cmd = mob_pkg::CMD_OPSTART;
        end
        return r;
    endfunction

    // enter a phase with its enter action chained in
    function automatic mob_pkg::t_step_res enter(
        mob_pkg::t_step_res base, mob_pkg::t_phase next, logic rec_unlocked,
        logic skip);
        mob_pkg::t_step_res r;
        r = base;
        case (next)
            mob_pkg::PH_DEPENDENCY: begin
                if (skip) begin
                    r.phase = mob_pkg::PH_OFFLINE;
                    r = configure(r, rec_unlocked, 1'b1);
                end else begin
                    r.phase = mob_pkg::PH_DEPENDENCY;
                    r = configure(r, rec_unlocked, 1'b0);
                end
            end
            mob_pkg::PH_OFFLINE: begin
                r.phase = mob_pkg::PH_OFFLINE;
                r = configure(r, rec_unlocked, 1'b1);
            end
            default: begin
                // not installed and enabled both restart the sequence
                r.phase = next;
                r.flags.attr_sent   = 1'b0;
                r.flags.attr_acked  = 1'b0;
                r.flags.unlock_sent = 1'b0;
                r.flags.start_sent  = 1'b0;
            end
        endcase
        return r;
    endfunction

    // state change report handling
    function automatic mob_pkg::t_step_res state_report(
        mob_pkg::t_step_res base, mob_pkg::t_event ev, logic skip);
        mob_pkg::t_step_res r;
        logic gone;
        logic offl;
        logic dep;
        r    = base;
        gone = (ev.new_availability == mob_pkg::AV_NOT_INSTALLED)
            || (ev.new_availability == mob_pkg::AV_POWER_OFF);
        offl = (ev.new_availability == mob_pkg::AV_OFF_LINE)
            || (ev.new_availability == mob_pkg::AV_OK);
        dep  = (ev.new_availability == mob_pkg::AV_DEPENDENCY);
        if (base.phase == mob_pkg::PH_ENABLED) begin
            if (ev.new_enabled) r = base;
            else if (gone) r = enter(base, mob_pkg::PH_NOT_INSTALLED,
                                     ev.recorded_unlocked, skip);
            else if (dep) r = enter(base, mob_pkg::PH_DEPENDENCY,
                                    ev.recorded_unlocked, skip);
            else if (offl) r = enter(base, mob_pkg::PH_OFFLINE,
                                     ev.recorded_unlocked, skip);
        end else if (ev.new_enabled) begin
            r = enter(base, mob_pkg::PH_ENABLED, ev.recorded_unlocked, skip);
        end else if (base.phase == mob_pkg::PH_NOT_INSTALLED) begin
            if (dep) r = enter(base, mob_pkg::PH_DEPENDENCY,
                               ev.recorded_unlocked, skip);
            else if (offl) r = enter(base, mob_pkg::PH_OFFLINE,
                                     ev.recorded_unlocked, skip);
        end else if (gone) begin
            r = enter(base, mob_pkg::PH_NOT_INSTALLED, ev.recorded_unlocked, skip);
        end else if (base.phase == mob_pkg::PH_DEPENDENCY) begin
            if (offl) r = enter(base, mob_pkg::PH_OFFLINE,
                                ev.recorded_unlocked, skip);
            else if (dep) r = configure(base, ev.new_unlocked, 1'b0);
        end else begin
            // offline
            if (dep && !skip) r = enter(base, mob_pkg::PH_DEPENDENCY,
                                        ev.recorded_unlocked, skip);
            else if (dep || offl) r = configure(base, ev.new_unlocked, 1'b1);
        end
        return r;
    endfunction

    // event dispatch
    always_comb begin
        mob_pkg::t_step_res base;
        base.phase    = i_phase;
        base.flags    = i_flags;
        base.cmd      = mob_pkg::CMD_NONE;
        base.rejected = 1'b0;
        o_res = base;
        case (mob_pkg::t_op'(i_event.op))
            mob_pkg::OP_SW_ACT_REP: begin
                o_res.rejected = (i_phase != mob_pkg::PH_NOT_INSTALLED);
            end
            mob_pkg::OP_STATE_REPORT: begin
                o_res = state_report(base, i_event, i_skip_offline);
            end
            mob_pkg::OP_ATTR_ACK: begin
                if (i_phase == mob_pkg::PH_DEPENDENCY
                    || i_phase == mob_pkg::PH_OFFLINE) begin
                    base.flags.attr_acked = 1'b1;
                    base.flags.attr_sent  = 1'b0;
                    o_res = configure(base, i_event.recorded_unlocked,
                                      i_phase == mob_pkg::PH_OFFLINE);
                end else begin
                    o_res.rejected = 1'b1;
                end
            end
            mob_pkg::OP_OPSTART_ACK, mob_pkg::OP_OPSTART_NACK: begin
                o_res.flags.start_sent = 1'b0;
            end
            mob_pkg::OP_FORCE_LOCK: begin
                o_res.flags.forced_lock = i_event.lock_request;
                o_res.cmd = i_event.lock_request ? mob_pkg::CMD_LOCK
                                                 : mob_pkg::CMD_UNLOCK;
            end
            mob_pkg::OP_LINK_DOWN: begin
                if (i_phase != mob_pkg::PH_NOT_INSTALLED) begin
                    o_res = enter(base, mob_pkg::PH_NOT_INSTALLED,
                                  i_event.recorded_unlocked, i_skip_offline);
                end
            end
            default: begin
                o_res.rejected = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/managed_object_bringup_fsm.sv
// top level of the managed object bring-up state machine: input register,
// phase and flag registers, result register; depends on mob_pkg, mob_step
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-------------------------------
// event    | in        | i_valid / o_ready          | operation, new_*, recorded_*, lock
// result   | out       | o_valid / i_ready          | command, current_state, rejected
// config   | in        | i_cfg_valid / o_cfg_ready  | peer_skips_offline
//
// one event per cycle sustained while results are taken; an accepted event passes
// through the input register, then the step logic into the result register
// state is updated as the event leaves the input register, so events chain
// back to back; synchronous active-low reset clears phase, flags and config
// a stalled result register holds the input register, which then drops o_ready
`timescale 1ns / 1ps
`default_nettype none

module managed_object_bringup_fsm (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_operation,
    input  wire logic       i_new_enabled,
    input  wire logic [2:0] i_new_availability,
    input  wire logic       i_new_unlocked,
    input  wire logic       i_recorded_unlocked,
    input  wire logic       i_lock_request,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_peer_skips_offline,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_command,
    output logic [1:0]      o_current_state,
    output logic            o_rejected
);

    logic               r_in_valid;
    mob_pkg::t_event    r_in;
    mob_pkg::t_phase    r_phase;
    mob_pkg::t_flags    r_flags;
    logic               r_skip;
    logic               r_out_valid;
    mob_pkg::t_cmd      r_out_cmd;
    mob_pkg::t_phase    r_out_phase;
    logic               r_out_rej;
    mob_pkg::t_step_res step;
    logic               advance;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
        end else if (i_cfg_valid) begin
            r_skip <= i_cfg_peer_skips_offline;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= '{op: i_operation, new_enabled: i_new_enabled,
                      new_availability: i_new_availability,
                      new_unlocked: i_new_unlocked,
                      recorded_unlocked: i_recorded_unlocked,
                      lock_request: i_lock_request};
        end
    end

    // event decision logic
    mob_step u_step (
        .i_event        (r_in),
        .i_phase        (r_phase),
        .i_flags        (r_flags),
        .i_skip_offline (r_skip),
        .o_res          (step)
    );

    // phase and flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mob_pkg::PH_NOT_INSTALLED;
            r_flags <= '0;
        end else if (advance) begin
            r_phase <= step.phase;
            r_flags <= step.flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_cmd   <= step.cmd;
            r_out_phase <= step.phase;
            r_out_rej   <= step.rejected;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_command       = r_out_cmd;
    assign o_current_state = r_out_phase;
    assign o_rejected      = r_out_rej;

    // a rejected event leaves phase and flags untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step.rejected) |=>
            (r_phase == $past(r_phase) && r_flags == $past(r_flags)))
        else $error("rejected event changed state");

    // a rejected result carries no command
    a_reject_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_command == mob_pkg::CMD_NONE))
        else $error("rejected result with a command");

    // in the not-installed and enabled phases the configure flags stay clear
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mob_pkg::PH_NOT_INSTALLED || r_phase == mob_pkg::PH_ENABLED)
            |-> (!r_flags.attr_sent && !r_flags.attr_acked
                 && !r_flags.unlock_sent && !r_flags.start_sent))
        else $error("configure flags set in a settled phase");

    // the input side only stalls behind a held event
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a held result");

endmodule

`default_nettype wire

>>> bench/tb_managed_object_bringup_fsm.sv
// self-checking bench for managed_object_bringup_fsm: directed and random event streams
// with bursty events, result back-pressure and config writes; depends on mob_pkg and the rtl
`timescale 1ns / 1ps

module tb_managed_object_bringup_fsm;

    // codes the package does not name that the fields still allow
    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam logic [2:0] AV_OTHER     = 3'd5;
    localparam logic [2:0] AV_RESERVED  = 3'd6;
    localparam logic [2:0] AV_UNDEFINED = 3'd7;

    typedef struct {
        mob_pkg::t_cmd   cmd;
        mob_pkg::t_phase ph;
        logic            rej;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // event channel
    logic            i_valid = 1'b0;
    mob_pkg::t_event ev_out = '0;
    logic            o_ready;
    wire logic [2:0] i_operation         = ev_out.op;
    wire logic       i_new_enabled       = ev_out.new_enabled;
    wire logic [2:0] i_new_availability  = ev_out.new_availability;
    wire logic       i_new_unlocked      = ev_out.new_unlocked;
    wire logic       i_recorded_unlocked = ev_out.recorded_unlocked;
    wire logic       i_lock_request      = ev_out.lock_request;

    // config channel
    logic i_cfg_valid = 1'b0;
    logic i_cfg_peer_skips_offline = 1'b0;
    logic o_cfg_ready;

    // result channel
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_command;
    logic [1:0] o_current_state;
    logic       o_rejected;

    managed_object_bringup_fsm dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_operation              (i_operation),
        .i_new_enabled            (i_new_enabled),
        .i_new_availability       (i_new_availability),
        .i_new_unlocked           (i_new_unlocked),
        .i_recorded_unlocked      (i_recorded_unlocked),
        .i_lock_request           (i_lock_request),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_peer_skips_offline (i_cfg_peer_skips_offline),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_command                (o_command),
        .o_current_state          (o_current_state),
        .o_rejected               (o_rejected)
    );

    always #10 i_clk = ~i_clk;

    mob_pkg::t_event events_to_send[$];
    t_reply          replies_due[$];
    int              mismatches = 0;

    // ---------------------------------------------------------------------
    // object tracker: own copy of phase, flags and config
    // ---------------------------------------------------------------------
    logic            skip_offline = 1'b0;
    mob_pkg::t_phase obj_phase = mob_pkg::PH_NOT_INSTALLED;
    logic            attr_sent = 1'b0, attr_acked = 1'b0, unlock_sent = 1'b0;
    logic            start_sent = 1'b0, forced_lock = 1'b0;

    function automatic void clear_progress();
        attr_sent   = 1'b0;
        attr_acked  = 1'b0;
        unlock_sent = 1'b0;
        start_sent  = 1'b0;
    endfunction

    // configure pass, at most one command
    function automatic mob_pkg::t_cmd configure_pass(logic unlocked, logic allow_start);
        if (!attr_sent && !attr_acked) begin
            attr_sent = 1'b1;
            return mob_pkg::CMD_SET_ATTR;
        end
        if (!unlocked && attr_acked && !unlock_sent) begin
            unlock_sent = 1'b1;
            return mob_pkg::CMD_UNLOCK;
        end
        if (allow_start && unlocked && attr_acked && !start_sent) begin
            start_sent = 1'b1;
            return mob_pkg::CMD_OPSTART;
        end
        return mob_pkg::CMD_NONE;
    endfunction

    // phase entry with its enter action, dependency may chain into offline
    function automatic mob_pkg::t_cmd enter_phase(mob_pkg::t_phase nxt, logic rec_unl);
        case (nxt)
            mob_pkg::PH_NOT_INSTALLED: begin
                obj_phase = mob_pkg::PH_NOT_INSTALLED;
                clear_progress();
                return mob_pkg::CMD_NONE;
            end
            mob_pkg::PH_DEPENDENCY: begin
                if (skip_offline) begin
                    obj_phase = mob_pkg::PH_OFFLINE;
                    return configure_pass(rec_unl, 1'b1);
                end
                obj_phase = mob_pkg::PH_DEPENDENCY;
                return configure_pass(rec_unl, 1'b0);
            end
            mob_pkg::PH_OFFLINE: begin
                obj_phase = mob_pkg::PH_OFFLINE;
                return configure_pass(rec_unl, 1'b1);
            end
            default: begin
                obj_phase = mob_pkg::PH_ENABLED;
                clear_progress();
                return mob_pkg::CMD_NONE;
            end
        endcase
    endfunction

    function automatic mob_pkg::t_cmd apply_state_report(mob_pkg::t_event e);
        logic gone, offl, dep;
        gone = (e.new_availability == mob_pkg::AV_NOT_INSTALLED)
            || (e.new_availability == mob_pkg::AV_POWER_OFF);
        offl = (e.new_availability == mob_pkg::AV_OFF_LINE)
            || (e.new_availability == mob_pkg::AV_OK);
        dep  = (e.new_availability == mob_pkg::AV_DEPENDENCY);
        if (obj_phase == mob_pkg::PH_ENABLED) begin
            if (e.new_enabled) return mob_pkg::CMD_NONE;
            if (gone) return enter_phase(mob_pkg::PH_NOT_INSTALLED, e.recorded_unlocked);
            if (dep) return enter_phase(mob_pkg::PH_DEPENDENCY, e.recorded_unlocked);
            if (offl) return enter_phase(mob_pkg::PH_OFFLINE, e.recorded_unlocked);
            return mob_pkg::CMD_NONE;
        end
        if (e.new_enabled) return enter_phase(mob_pkg::PH_ENABLED, e.recorded_unlocked);
        if (obj_phase == mob_pkg::PH_NOT_INSTALLED) begin
            if (dep) return enter_phase(mob_pkg::PH_DEPENDENCY, e.recorded_unlocked);
            if (offl) return enter_phase(mob_pkg::PH_OFFLINE, e.recorded_unlocked);
            return mob_pkg::CMD_NONE;
        end
        if (gone) return enter_phase(mob_pkg::PH_NOT_INSTALLED, e.recorded_unlocked);
        if (obj_phase == mob_pkg::PH_DEPENDENCY) begin
            if (offl) return enter_phase(mob_pkg::PH_OFFLINE, e.recorded_unlocked);
            if (dep) return configure_pass(e.new_unlocked, 1'b0);
            return mob_pkg::CMD_NONE;
        end
        // offline
        if (dep) begin
            if (!skip_offline)
                return enter_phase(mob_pkg::PH_DEPENDENCY, e.recorded_unlocked);
            return configure_pass(e.new_unlocked, 1'b1);
        end
        if (offl) return configure_pass(e.new_unlocked, 1'b1);
        return mob_pkg::CMD_NONE;
    endfunction

    // one event in, one reply out
    function automatic t_reply advance_object(mob_pkg::t_event e);
        t_reply r;
        r.cmd = mob_pkg::CMD_NONE;
        r.rej = 1'b0;
        case (e.op)
            mob_pkg::OP_SW_ACT_REP: begin
                if (obj_phase != mob_pkg::PH_NOT_INSTALLED) r.rej = 1'b1;
            end
            mob_pkg::OP_STATE_REPORT: r.cmd = apply_state_report(e);
            mob_pkg::OP_ATTR_ACK: begin
                if (obj_phase == mob_pkg::PH_DEPENDENCY
                    || obj_phase == mob_pkg::PH_OFFLINE) begin
                    attr_acked = 1'b1;
                    attr_sent  = 1'b0;
                    r.cmd = configure_pass(e.recorded_unlocked,
                                           obj_phase == mob_pkg::PH_OFFLINE);
                end else begin
                    r.rej = 1'b1;
                end
            end
            mob_pkg::OP_OPSTART_ACK, mob_pkg::OP_OPSTART_NACK: start_sent = 1'b0;
            mob_pkg::OP_FORCE_LOCK: begin
                forced_lock = e.lock_request;
                if (e.lock_request) r.cmd = mob_pkg::CMD_LOCK;
                else r.cmd = mob_pkg::CMD_UNLOCK;
            end
            mob_pkg::OP_LINK_DOWN: begin
                if (obj_phase != mob_pkg::PH_NOT_INSTALLED)
                    r.cmd = enter_phase(mob_pkg::PH_NOT_INSTALLED, e.recorded_unlocked);
            end
            default: r.rej = 1'b1;
        endcase
        r.ph = obj_phase;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // tracker update on accepted transactions, and result checking
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            skip_offline = 1'b0;
            obj_phase    = mob_pkg::PH_NOT_INSTALLED;
            clear_progress();
            forced_lock  = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                skip_offline = i_cfg_peer_skips_offline;
            if (i_valid && o_ready)
                replies_due.push_back(advance_object(ev_out));
            if (o_valid && i_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result transaction with nothing pending");
                end else begin
                    want = replies_due.pop_front();
                    if (o_command !== want.cmd)
                        report_mismatch($sformatf("command %0d, want %0d", o_command, want.cmd));
                    if (o_current_state !== want.ph)
                        report_mismatch($sformatf("state %0d, want %0d",
                                                  o_current_state, want.ph));
                    if (o_rejected !== want.rej)
                        report_mismatch($sformatf("rejected %0b, want %0b",
                                                  o_rejected, want.rej));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // event driver: bursts of random length with random gaps
    // ---------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (events_to_send.size() > 0) begin
                ev_out  <= events_to_send.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result receiver: random stall patterns, plus long holds
    // ---------------------------------------------------------------------
    int   rx_cycle = 0;
    int   rx_mode = 0;
    int   hold_left = 0;
    logic rx_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode <= $urandom_range(0, 3);
            // long hold-off so the block fills up and stalls its input
            if (rx_cycle % 3000 == 1000)
                hold_left <= 150;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            case (rx_mode)
                0: rx_ready = 1'b1;
                1: rx_ready = $urandom_range(0, 1);
                2: rx_ready = ($urandom_range(0, 3) == 0);
                default: rx_ready = rx_cycle[0];
            endcase
            if (hold_left > 0)
                rx_ready = 1'b0;
            i_ready <= rx_ready;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic mob_pkg::t_event mk(logic [2:0] op);
        mob_pkg::t_event e;
        e.op                = op;
        e.new_enabled       = $urandom_range(0, 1);
        e.new_availability  = $urandom_range(0, 7);
        e.new_unlocked      = $urandom_range(0, 1);
        e.recorded_unlocked = $urandom_range(0, 1);
        e.lock_request      = $urandom_range(0, 1);
        return e;
    endfunction

    function automatic mob_pkg::t_event fixed_ev(logic [2:0] op, logic en, logic [2:0] av,
                                                 logic nu, logic ru, logic lk);
        mob_pkg::t_event e;
        e.op                = op;
        e.new_enabled       = en;
        e.new_availability  = av;
        e.new_unlocked      = nu;
        e.recorded_unlocked = ru;
        e.lock_request      = lk;
        return e;
    endfunction

    function automatic mob_pkg::t_event report_ev(logic en, logic [2:0] av);
        mob_pkg::t_event e;
        e = mk(mob_pkg::OP_STATE_REPORT);
        e.new_enabled = en;
        e.new_availability = av;
        return e;
    endfunction

    // availability that moves a disabled object forward
    function automatic logic [2:0] pick_up_av();
        case ($urandom_range(0, 2))
            0: return mob_pkg::AV_DEPENDENCY;
            1: return mob_pkg::AV_OFF_LINE;
            default: return mob_pkg::AV_OK;
        endcase
    endfunction

    // one well-formed bring-up and tear-down with random content
    task automatic queue_bringup_episode();
        int n_ack;
        if ($urandom_range(0, 1)) events_to_send.push_back(mk(mob_pkg::OP_SW_ACT_REP));
        events_to_send.push_back(report_ev(1'b0, pick_up_av()));
        n_ack = $urandom_range(0, 2);
        for (int k = 0; k < n_ack; k++) begin
            events_to_send.push_back(mk(mob_pkg::OP_ATTR_ACK));
            if ($urandom_range(0, 1)) events_to_send.push_back(report_ev(1'b0, pick_up_av()));
        end
        events_to_send.push_back(report_ev(1'b0, $urandom_range(0, 1) ?
                                           mob_pkg::AV_OFF_LINE : mob_pkg::AV_OK));
        events_to_send.push_back(mk(mob_pkg::OP_ATTR_ACK));
        if ($urandom_range(0, 1)) begin
            events_to_send.push_back(mk($urandom_range(0, 1) ?
                                        mob_pkg::OP_OPSTART_ACK : mob_pkg::OP_OPSTART_NACK));
            events_to_send.push_back(report_ev(1'b0, pick_up_av()));
        end
        if ($urandom_range(0, 3) == 0) events_to_send.push_back(mk(mob_pkg::OP_FORCE_LOCK));
        if ($urandom_range(0, 3) != 0) begin
            events_to_send.push_back(report_ev(1'b1, $urandom_range(0, 7)));
            if ($urandom_range(0, 1)) events_to_send.push_back(mk(mob_pkg::OP_STATE_REPORT));
        end
        case ($urandom_range(0, 2))
            0: events_to_send.push_back(mk(mob_pkg::OP_LINK_DOWN));
            1: events_to_send.push_back(report_ev(1'b0, $urandom_range(0, 1) ?
                                                  mob_pkg::AV_NOT_INSTALLED :
                                                  mob_pkg::AV_POWER_OFF));
            default: events_to_send.push_back(report_ev(1'b0, pick_up_av()));
        endcase
    endtask

    // mostly well-formed episodes, the rest fully random events
    task automatic queue_random_events(int count);
        int queued;
        int before_sz;
        queued = 0;
        while (queued < count) begin
            before_sz = events_to_send.size();
            if ($urandom_range(0, 3) != 0)
                queue_bringup_episode();
            else
                events_to_send.push_back(mk($urandom_range(0, 7)));
            queued += events_to_send.size() - before_sz;
        end
    endtask

    task automatic write_skip_offline(logic value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_peer_skips_offline <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (events_to_send.size() != 0 || i_valid || replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // normal peer: walk through every phase and the corner events
        write_skip_offline(1'b0);
        events_to_send.push_back(fixed_ev(mob_pkg::OP_SW_ACT_REP, 0,
                                          mob_pkg::AV_NOT_INSTALLED, 0, 0, 0));
        events_to_send.push_back(fixed_ev(OP_UNDEFINED, 1, AV_UNDEFINED, 1, 1, 1));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_ATTR_ACK, 0, mob_pkg::AV_OK, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0, AV_OTHER, 1, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_SW_ACT_REP, 1, mob_pkg::AV_OK, 1, 1, 1));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_ATTR_ACK, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_OK, 0, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_OPSTART_NACK, 0,
                                          mob_pkg::AV_OK, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_OFF_LINE, 1, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_FORCE_LOCK, 0, mob_pkg::AV_OK, 0, 0, 1));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_FORCE_LOCK, 1, mob_pkg::AV_OK, 1, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 1, AV_UNDEFINED, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 1,
                                          mob_pkg::AV_NOT_INSTALLED, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_ATTR_ACK, 0, mob_pkg::AV_OK, 1, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_LINK_DOWN, 0, mob_pkg::AV_OK, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_LINK_DOWN, 1, mob_pkg::AV_OK, 1, 1, 1));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_OPSTART_ACK, 0,
                                          mob_pkg::AV_OK, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_POWER_OFF, 0, 0, 0));
        wait_drained();

        // peer that skips offline: dependency lands in offline
        write_skip_offline(1'b1);
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_ATTR_ACK, 0,
                                          mob_pkg::AV_DEPENDENCY, 0, 1, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0, AV_RESERVED, 0, 0, 0));
        events_to_send.push_back(fixed_ev(mob_pkg::OP_STATE_REPORT, 0,
                                          mob_pkg::AV_NOT_INSTALLED, 0, 0, 0));
        wait_drained();

        // random phases with alternating and random config
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) write_skip_offline(ph[0]);
            else write_skip_offline($urandom_range(0, 1));
            queue_random_events(225);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/mob_pkg.sv
src/mob_step.sv
src/managed_object_bringup_fsm.sv
bench/tb_managed_object_bringup_fsm.sv
